// ===== src/asfr_pkg.sv =====
// ----------------------------------------------------------------------------
// asfr_pkg
// shared constants and controller/datapath signal groups of the frame receiver
// ----------------------------------------------------------------------------
package asfr_pkg;

  // payload store depth and emitted run limit
  localparam int PayloadDepth = 16;
  localparam int MaxEmit      = 16;
  localparam int EmitLimit    = (PayloadDepth < MaxEmit) ? PayloadDepth : MaxEmit;
  localparam int AddrW        = $clog2(PayloadDepth);
  localparam int IdxW         = (EmitLimit > 1) ? $clog2(EmitLimit) : 1;
  localparam int CntW         = $clog2(EmitLimit + 1);

  // header layout
  localparam int HeaderBytes  = 5;
  localparam logic [15:0] HdrAddrPos = 16'd1;
  localparam logic [15:0] HdrFuncPos = 16'd2;
  localparam logic [15:0] HdrLenLoPos = 16'd3;
  localparam logic [15:0] HdrLenHiPos = 16'(HeaderBytes - 1);

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegNodeAddress      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBroadcastAddress = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStartByte        = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMuteTicks        = 3'd3;

  // input command codes
  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic hdr_open;   // start byte seen, header position becomes one
    logic hdr_store;  // header byte at the current position
    logic pay_store;  // payload byte at the current position
    logic count_clr;  // byte position back to zero
    logic mute_open;  // foreign frame, restart the mute counter
    logic mute_tick;  // one mute timer tick
    logic emit_next;  // current result word taken
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_match;
    logic hdr_last;
    logic addr_match;
    logic pay_more;
    logic mute_done;
    logic emit_last;
  } ctrl_sts_t;

endpackage

// ===== src/asfr_in_if.sv =====
// ----------------------------------------------------------------------------
// asfr_in_if
// input channel: one bus byte or one mute timer tick per word
// ----------------------------------------------------------------------------
interface asfr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// ===== src/asfr_out_if.sv =====
// ----------------------------------------------------------------------------
// asfr_out_if
// output channel: one stored payload byte of a closed frame per word
// ----------------------------------------------------------------------------
interface asfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_function;
  logic [15:0] out_length;
  logic [3:0]  byte_index;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        truncated;
  logic        last;

  modport source (output valid, output out_function, output out_length,
                  output byte_index, output payload_byte, output byte_valid,
                  output truncated, output last, input ready);
  modport sink   (input valid, input out_function, input out_length,
                  input byte_index, input payload_byte, input byte_valid,
                  input truncated, input last, output ready);
endinterface

// ===== src/addressed_serial_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// addressed_serial_frame_receiver_unit
// address filtered serial frame receiver with mute after foreign frames
// ----------------------------------------------------------------------------
// usage
//   in_i carries one word per bus byte (cmd 0) or mute timer tick (cmd 1);
//   out_o carries one word per stored payload byte of a closed frame
//   a frame is start byte, address, function, length low, length high,
//   then length payload bytes and one closing byte whose value is unused
//   every input word is taken while no result run is pending
//   the closing byte starts a run of min(length, 16) words (one word with
//   byte_valid low for an empty payload), the first in the next cycle and then
//   one per cycle while out_o.ready is high; the run is paced by out_o.ready,
//   and in_i.ready is low meanwhile
//   a stall on out_o holds the current word and keeps in_i blocked
//   foreign frames mute the receiver: bytes are dropped until mute_ticks
//   ticks arrive (a zero setting gives sixteen ticks)
//   cfg_we_i writes register cfg_idx_i (0 node, 1 broadcast, 2 start byte,
//   3 mute ticks); other indexes are ignored
//   reset returns to idle with default registers; there is no clearing pass,
//   each emitted byte is written by its own frame before it is read
// ----------------------------------------------------------------------------
module addressed_serial_frame_receiver_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [asfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                   cfg_data_i,
  asfr_in_if.sink                      in_i,
  asfr_out_if.source                   out_o
);

  asfr_pkg::ctrl_cmd_t ctrl_cmd;
  asfr_pkg::ctrl_sts_t ctrl_sts;

  // controller: frame phases and both handshakes
  asfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (ctrl_sts),
    .cmd_o       (ctrl_cmd)
  );

  // datapath: registers, counters, payload store and result fields
  asfr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (in_i.rx_byte),
    .cmd_i          (ctrl_cmd),
    .sts_o          (ctrl_sts),
    .out_function_o (out_o.out_function),
    .out_length_o   (out_o.out_length),
    .byte_index_o   (out_o.byte_index),
    .payload_byte_o (out_o.payload_byte),
    .byte_valid_o   (out_o.byte_valid),
    .truncated_o    (out_o.truncated),
    .last_o         (out_o.last)
  );

endmodule

// ===== src/asfr_ram.sv =====
// ----------------------------------------------------------------------------
// asfr_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module asfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/asfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// asfr_ctrl
// frame state machine: idle, header, payload, mute and result run
// ----------------------------------------------------------------------------
module asfr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  asfr_pkg::ctrl_sts_t  sts_i,
  output asfr_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StHeader  = 3'd1;
  localparam logic [2:0] StPayload = 3'd2;
  localparam logic [2:0] StMute    = 3'd3;
  localparam logic [2:0] StEmit    = 3'd4;

  logic [2:0] state_q, state_d;
  logic       in_fire, is_byte, is_tick;

  assign in_ready_o  = (state_q != StEmit);
  assign out_valid_o = (state_q == StEmit);
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_byte     = in_fire && (in_cmd_i == asfr_pkg::CmdByte);
  assign is_tick     = in_fire && (in_cmd_i == asfr_pkg::CmdTick);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (is_byte && sts_i.start_match) begin
          cmd_o.hdr_open = 1'b1;
          state_d        = StHeader;
        end
      end
      StHeader: begin
        if (is_byte) begin
          cmd_o.hdr_store = 1'b1;
          if (sts_i.hdr_last) begin
            if (sts_i.addr_match) begin
              state_d = StPayload;
            end else begin
              cmd_o.mute_open = 1'b1;
              state_d         = StMute;
            end
          end
        end
      end
      StPayload: begin
        if (is_byte) begin
          if (sts_i.pay_more) begin
            cmd_o.pay_store = 1'b1;
          end else begin
            // closing byte, value unused
            cmd_o.count_clr = 1'b1;
            state_d         = StEmit;
          end
        end
      end
      StMute: begin
        if (is_tick) begin
          cmd_o.mute_tick = 1'b1;
          if (sts_i.mute_done) begin
            cmd_o.count_clr = 1'b1;
            state_d         = StIdle;
          end
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          cmd_o.emit_next = 1'b1;
          if (sts_i.emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/asfr_dp.sv =====
// ----------------------------------------------------------------------------
// asfr_dp
// frame datapath: config registers, header fields, counters, payload store
// ----------------------------------------------------------------------------
module asfr_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [asfr_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [7:0]                          cfg_data_i,
  input  logic [7:0]                          rx_byte_i,
  input  asfr_pkg::ctrl_cmd_t                 cmd_i,
  output asfr_pkg::ctrl_sts_t                 sts_o,
  output logic [7:0]                          out_function_o,
  output logic [15:0]                         out_length_o,
  output logic [3:0]                          byte_index_o,
  output logic [7:0]                          payload_byte_o,
  output logic                                byte_valid_o,
  output logic                                truncated_o,
  output logic                                last_o
);

  logic [7:0]  node_addr_q, bcast_addr_q, start_byte_q;
  logic [3:0]  mute_ticks_q;
  logic [15:0] count_q, count_d;
  logic [7:0]  hdr_addr_q, hdr_func_q;
  logic [15:0] len_q;
  logic [3:0]  mute_cnt_q, mute_cnt_d, mute_cnt_inc;
  logic [asfr_pkg::IdxW-1:0] idx_q, idx_d;
  logic [asfr_pkg::CntW-1:0] emit_n, idx_plus;
  logic        over_limit;
  logic        ram_we;
  logic [7:0]  ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q  <= 8'd1;
      bcast_addr_q <= 8'd255;
      start_byte_q <= 8'd58;
      mute_ticks_q <= 4'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asfr_pkg::RegNodeAddress:      node_addr_q  <= cfg_data_i;
        asfr_pkg::RegBroadcastAddress: bcast_addr_q <= cfg_data_i;
        asfr_pkg::RegStartByte:        start_byte_q <= cfg_data_i;
        asfr_pkg::RegMuteTicks:        mute_ticks_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // status toward the controller
  assign mute_cnt_inc      = mute_cnt_q + 4'd1;
  assign over_limit        = (len_q > 16'(asfr_pkg::EmitLimit));
  assign emit_n            = over_limit ? asfr_pkg::CntW'(asfr_pkg::EmitLimit)
                                        : asfr_pkg::CntW'(len_q);
  assign idx_plus          = asfr_pkg::CntW'(idx_q) + asfr_pkg::CntW'(1);

  assign sts_o.start_match = (rx_byte_i == start_byte_q);
  assign sts_o.hdr_last    = (count_q == asfr_pkg::HdrLenHiPos);
  assign sts_o.addr_match  = (hdr_addr_q == node_addr_q) || (hdr_addr_q == bcast_addr_q);
  assign sts_o.pay_more    = (count_q < len_q);
  assign sts_o.mute_done   = (mute_cnt_inc == mute_ticks_q);
  assign sts_o.emit_last   = (emit_n == '0) || (idx_plus == emit_n);

  // byte position within header or payload
  always_comb begin
    count_d = count_q;
    if (cmd_i.hdr_open) begin
      count_d = 16'd1;
    end else if (cmd_i.hdr_store) begin
      count_d = sts_o.hdr_last ? 16'd0 : count_q + 16'd1;
    end else if (cmd_i.pay_store) begin
      count_d = count_q + 16'd1;
    end else if (cmd_i.count_clr) begin
      count_d = 16'd0;
    end
  end

  // mute counter, wraps at four bits
  always_comb begin
    mute_cnt_d = mute_cnt_q;
    if (cmd_i.mute_open) begin
      mute_cnt_d = 4'd0;
    end else if (cmd_i.mute_tick) begin
      mute_cnt_d = sts_o.mute_done ? 4'd0 : mute_cnt_inc;
    end
  end

  // result index, read address runs one ahead on each taken word
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.emit_next) begin
      idx_d = sts_o.emit_last ? '0 : asfr_pkg::IdxW'(idx_plus);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= 16'd0;
      hdr_addr_q <= 8'd0;
      hdr_func_q <= 8'd0;
      len_q      <= 16'd0;
      mute_cnt_q <= 4'd0;
      idx_q      <= '0;
    end else begin
      count_q    <= count_d;
      mute_cnt_q <= mute_cnt_d;
      idx_q      <= idx_d;
      if (cmd_i.hdr_store) begin
        case (count_q)
          asfr_pkg::HdrAddrPos:  hdr_addr_q  <= rx_byte_i;
          asfr_pkg::HdrFuncPos:  hdr_func_q  <= rx_byte_i;
          asfr_pkg::HdrLenLoPos: len_q[7:0]  <= rx_byte_i;
          asfr_pkg::HdrLenHiPos: len_q[15:8] <= rx_byte_i;
          default: ;
        endcase
      end
    end
  end

  // payload store, bytes beyond the depth are dropped
  assign ram_we = cmd_i.pay_store && (count_q < 16'(asfr_pkg::PayloadDepth));

  asfr_ram #(
    .Width (8),
    .Depth (asfr_pkg::PayloadDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[asfr_pkg::AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (asfr_pkg::AddrW'(idx_d)),
    .rdata_o (ram_rdata)
  );

  // result word fields
  assign out_function_o = hdr_func_q;
  assign out_length_o   = len_q;
  assign byte_index_o   = 4'(idx_q);
  assign byte_valid_o   = (emit_n != '0);
  assign payload_byte_o = byte_valid_o ? ram_rdata : 8'd0;
  assign truncated_o    = over_limit;
  assign last_o         = sts_o.emit_last;

endmodule
